// ===== design/srl_pkg.sv =====
// ----------------------------------------------------------------------------
// srl_pkg
// Shared types and constants for the servo linear ramp unit.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam int ANGLE_W     = 8;
  localparam int DUR_W       = 16;
  localparam int PERIOD_W    = 7;
  localparam int TICK_W      = 17;
  localparam int ELAPSED_W   = 24;
  localparam int QBIT_W      = 3;
  localparam int IO_CHANNELS = 4;

  localparam logic [ANGLE_W-1:0]  REST_ANGLE        = 8'd90;
  localparam logic [PERIOD_W-1:0] RESET_TICK_PERIOD = 7'd10;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PROD,
    S_DIV,
    S_WRITE,
    S_EMIT_STEP,
    S_EMIT_DONE
  } srl_state_t;

  typedef struct packed {
    logic short_move;
    logic long_move;
    logic tick_start;
    logic tick_finish;
    logic tick_step;
    logic prod;
    logic div_step;
    logic write_ch;
    logic load_out;
    logic out_done;
  } srl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic short_move;
    logic busy;
    logic reach_end;
    logic div_last;
    logic ch_last;
    logic res_hold;
  } srl_sts_t;

endpackage

// ===== design/srl_ctrl.sv =====
// ----------------------------------------------------------------------------
// srl_ctrl
// Sequencer: request decode, tick check, per-channel multiply/divide, result.
// ----------------------------------------------------------------------------
module srl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  srl_pkg::srl_sts_t sts,
  output srl_pkg::srl_cmd_t cmd
);

  srl_pkg::srl_state_t state;
  srl_pkg::srl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_ready  = 1'b0;
    unique case (state)
      srl_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (!sts.is_tick) begin
            if (sts.short_move) begin
              cmd.short_move = 1'b1;
              state_next     = srl_pkg::S_EMIT_DONE;
            end else begin
              cmd.long_move = 1'b1;
            end
          end else if (sts.busy) begin
            cmd.tick_start = 1'b1;
            state_next     = srl_pkg::S_CHECK;
          end
        end
      end
      srl_pkg::S_CHECK: begin
        if (sts.reach_end) begin
          cmd.tick_finish = 1'b1;
          state_next      = srl_pkg::S_EMIT_DONE;
        end else begin
          cmd.tick_step = 1'b1;
          state_next    = srl_pkg::S_PROD;
        end
      end
      srl_pkg::S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = srl_pkg::S_DIV;
      end
      srl_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = srl_pkg::S_WRITE;
        end
      end
      srl_pkg::S_WRITE: begin
        cmd.write_ch = 1'b1;
        state_next   = sts.ch_last ? srl_pkg::S_EMIT_STEP : srl_pkg::S_PROD;
      end
      srl_pkg::S_EMIT_STEP: begin
        if (!sts.res_hold) begin
          cmd.load_out = 1'b1;
          state_next   = srl_pkg::S_IDLE;
        end
      end
      srl_pkg::S_EMIT_DONE: begin
        if (!sts.res_hold) begin
          cmd.load_out = 1'b1;
          cmd.out_done = 1'b1;
          state_next   = srl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = srl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/srl_dp.sv =====
// ----------------------------------------------------------------------------
// srl_dp
// Angle state, tick arithmetic, shared multiplier and restoring divider,
// and the result register.
// ----------------------------------------------------------------------------
module srl_dp #(
  parameter int CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [srl_pkg::PERIOD_W-1:0]        tick_period_ms,
  input  logic                                command,
  input  logic [srl_pkg::DUR_W-1:0]           duration_ms,
  input  logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] targets,
  input  srl_pkg::srl_cmd_t                   cmd,
  output srl_pkg::srl_sts_t                   sts,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] angles,
  output logic                                move_done
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW   = srl_pkg::ANGLE_W;
  localparam int DW   = srl_pkg::DUR_W;
  localparam int EW   = srl_pkg::ELAPSED_W;
  localparam int TW   = srl_pkg::TICK_W;

  logic [srl_pkg::PERIOD_W-1:0] tick_period;
  logic [srl_pkg::PERIOD_W-1:0] period_used;
  logic [AW-1:0]                start_angles [CHANNELS];
  logic [AW-1:0]                goal_angles  [CHANNELS];
  logic [AW-1:0]                last_angles  [CHANNELS];
  logic [AW-1:0]                goal_load    [CHANNELS];
  logic [DW-1:0]                tick_number;
  logic [DW-1:0]                move_length;
  logic                         ramp_busy;
  logic [TW-1:0]                tick_n;
  logic [TW-1:0]                tick_n_next;
  logic [EW-1:0]                elapsed;
  logic [CH_W-1:0]              ch;
  logic [srl_pkg::QBIT_W-1:0]   bit_cnt;
  logic [DW-1:0]                div_rem;
  logic [AW-1:0]                div_q;
  logic [DW:0]                  trial;
  logic                         trial_ge;
  logic [AW-1:0]                cur_start;
  logic [AW-1:0]                cur_goal;
  logic                         dir_up;
  logic [AW-1:0]                diff;
  logic [EW-1:0]                mag;
  logic [AW-1:0]                step_angle;

  assign period_used = (tick_period == '0) ? srl_pkg::PERIOD_W'(1) : tick_period;
  assign tick_n_next = {1'b0, tick_number} + TW'(1);

  assign cur_start  = start_angles[ch];
  assign cur_goal   = goal_angles[ch];
  assign dir_up     = cur_goal >= cur_start;
  assign diff       = dir_up ? (cur_goal - cur_start) : (cur_start - cur_goal);
  assign mag        = EW'(diff) * EW'(elapsed[DW-1:0]);
  assign trial      = {div_rem, div_q[AW-1]};
  assign trial_ge   = trial >= {1'b0, move_length};
  assign step_angle = dir_up ? (cur_start + div_q) : (cur_start - div_q);

  always_comb begin
    sts.is_tick    = (command == srl_pkg::CMD_TICK);
    sts.short_move = {{(DW-srl_pkg::PERIOD_W){1'b0}}, period_used} >= duration_ms;
    sts.busy       = ramp_busy;
    sts.reach_end  = tick_n[TW-1] || (elapsed >= EW'(move_length));
    sts.div_last   = (bit_cnt == srl_pkg::QBIT_W'(AW-1));
    sts.ch_last    = (ch == CH_W'(CHANNELS-1));
    sts.res_hold   = res_valid && !res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= srl_pkg::RESET_TICK_PERIOD;
    end else if (cfg_valid) begin
      tick_period <= tick_period_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_number <= '0;
      move_length <= '0;
      ramp_busy   <= 1'b0;
    end else begin
      if (cmd.short_move) begin
        ramp_busy   <= 1'b0;
        tick_number <= '0;
      end
      if (cmd.long_move) begin
        ramp_busy   <= 1'b1;
        tick_number <= '0;
        move_length <= duration_ms;
      end
      if (cmd.tick_finish) begin
        ramp_busy   <= 1'b0;
        tick_number <= tick_n[DW-1:0];
      end
      if (cmd.tick_step) begin
        tick_number <= tick_n[DW-1:0];
      end
    end
  end

  // tick count and elapsed time, then per-channel multiply and divide
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      tick_n  <= tick_n_next;
      elapsed <= EW'(tick_n_next) * EW'(period_used);
    end
    if (cmd.tick_step) begin
      ch <= '0;
    end else if (cmd.write_ch && !sts.ch_last) begin
      ch <= ch + CH_W'(1);
    end
    if (cmd.prod) begin
      div_rem <= mag[EW-1:AW];
      div_q   <= mag[AW-1:0];
      bit_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= trial_ge ? DW'(trial - {1'b0, move_length}) : trial[DW-1:0];
      div_q   <= {div_q[AW-2:0], trial_ge};
      bit_cnt <= bit_cnt + srl_pkg::QBIT_W'(1);
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    if (g < srl_pkg::IO_CHANNELS) begin : g_io
      assign goal_load[g] = targets[g];

      always_ff @(posedge clk) begin
        if (rst) begin
          last_angles[g] <= srl_pkg::REST_ANGLE;
        end else if (cmd.short_move) begin
          last_angles[g] <= targets[g];
        end else if (cmd.tick_finish) begin
          last_angles[g] <= goal_angles[g];
        end else if (cmd.write_ch && (ch == CH_W'(g))) begin
          last_angles[g] <= step_angle;
        end
      end
    end else begin : g_hidden
      assign goal_load[g] = last_angles[g];

      always_ff @(posedge clk) begin
        if (rst) begin
          last_angles[g] <= srl_pkg::REST_ANGLE;
        end else if (cmd.tick_finish) begin
          last_angles[g] <= goal_angles[g];
        end else if (cmd.write_ch && (ch == CH_W'(g))) begin
          last_angles[g] <= step_angle;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.long_move) begin
        start_angles[g] <= last_angles[g];
        goal_angles[g]  <= goal_load[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      move_done <= cmd.out_done;
    end
  end

  for (genvar k = 0; k < srl_pkg::IO_CHANNELS; k++) begin : g_out
    if (k < CHANNELS) begin : g_live
      always_ff @(posedge clk) begin
        if (cmd.load_out) begin
          angles[k] <= last_angles[k];
        end
      end
    end else begin : g_zero
      assign angles[k] = '0;
    end
  end

endmodule

// ===== design/servo_linear_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// servo_linear_ramp_unit
// Linear ramp of several servo angles toward new targets, one step per tick.
// ----------------------------------------------------------------------------
// A move request with a duration at or below the tick period returns
// the targets with move_done set; a longer move returns nothing. A tick
// request while a ramp runs is served by one shared 8x16 multiplier and
// one restoring divider producing one quotient bit per cycle, which work
// through the channels in turn. The tick that reaches the duration
// returns the targets. A finished result sits in an output register, so
// the next request is taken while it waits.
module servo_linear_ramp_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srl_pkg::PERIOD_W-1:0]  tick_period_ms,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic                          command,
  input  logic [srl_pkg::DUR_W-1:0]     duration_ms,
  input  logic [srl_pkg::ANGLE_W-1:0]   target_a,
  input  logic [srl_pkg::ANGLE_W-1:0]   target_b,
  input  logic [srl_pkg::ANGLE_W-1:0]   target_c,
  input  logic [srl_pkg::ANGLE_W-1:0]   target_d,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [srl_pkg::ANGLE_W-1:0]   angle_a,
  output logic [srl_pkg::ANGLE_W-1:0]   angle_b,
  output logic [srl_pkg::ANGLE_W-1:0]   angle_c,
  output logic [srl_pkg::ANGLE_W-1:0]   angle_d,
  output logic                          move_done
);

  srl_pkg::srl_cmd_t cmd;
  srl_pkg::srl_sts_t sts;
  logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] targets;
  logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] angles;

  assign cfg_ready = 1'b1;
  assign targets   = {target_d, target_c, target_b, target_a};
  assign angle_a   = angles[0];
  assign angle_b   = angles[1];
  assign angle_c   = angles[2];
  assign angle_d   = angles[3];

  srl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srl_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .tick_period_ms (tick_period_ms),
    .command        (command),
    .duration_ms    (duration_ms),
    .targets        (targets),
    .cmd            (cmd),
    .sts            (sts),
    .res_ready      (res_ready),
    .res_valid      (res_valid),
    .angles         (angles),
    .move_done      (move_done)
  );

`ifndef SYNTH
  a_short_move_idles: assert property (@(posedge clk) disable iff (rst)
    cmd.short_move |=> !sts.busy)
    else $error("short move left the ramp running");

  a_step_needs_ramp: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && !cmd.out_done) |-> sts.busy)
    else $error("intermediate result without a running ramp");

  a_idle_tick_ignored: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && (command == srl_pkg::CMD_TICK) && !sts.busy)
      |=> (cmd_ready && !$rose(res_valid)))
    else $error("tick while idle was not ignored");
`endif

endmodule

// ===== bench/servo_linear_ramp_unit_tb.sv =====
// ----------------------------------------------------------------------------
// servo_linear_ramp_unit_tb
// Self-checking bench for the four-channel servo ramp. A scoreboard object
// tracks the ramp state (start, goal and last angles, tick count, period)
// and predicts the angles of every tick and short move. Directed requests
// cover the jump, ramp, restart and cancel cases first. Random move/tick
// bursts then run under several tick periods, with random idling on both
// channels, a long result stall and drains between the period changes.
// ----------------------------------------------------------------------------
module servo_linear_ramp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                                                cmd;
    logic [srl_pkg::DUR_W-1:0]                           dur;
    logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] tgt;
  } ramp_request_t;

  typedef struct packed {
    logic [srl_pkg::IO_CHANNELS-1:0][srl_pkg::ANGLE_W-1:0] ang;
    logic                                                done;
  } angle_result_t;

  class ramp_scoreboard;
    logic [srl_pkg::ANGLE_W-1:0]  start_ang [srl_pkg::IO_CHANNELS];
    logic [srl_pkg::ANGLE_W-1:0]  goal_ang [srl_pkg::IO_CHANNELS];
    logic [srl_pkg::ANGLE_W-1:0]  last_ang [srl_pkg::IO_CHANNELS];
    logic [srl_pkg::DUR_W-1:0]    tick_num;
    logic [srl_pkg::DUR_W-1:0]    move_len;
    bit                           busy;
    logic [srl_pkg::PERIOD_W-1:0] period;
    angle_result_t                expected_angles [$];
    int                           mismatches;

    function new();
      foreach (last_ang[i]) begin
        start_ang[i] = '0;
        goal_ang[i]  = '0;
        last_ang[i]  = srl_pkg::REST_ANGLE;
      end
      tick_num   = '0;
      move_len   = '0;
      busy       = 1'b0;
      period     = srl_pkg::RESET_TICK_PERIOD;
      mismatches = 0;
    endfunction

    function void set_period(logic [srl_pkg::PERIOD_W-1:0] p);
      period = p;
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction

    function int errors();
      return mismatches + expected_angles.size();
    endfunction

    function logic [srl_pkg::ANGLE_W-1:0] lerp(logic [srl_pkg::ANGLE_W-1:0] from,
                                               logic [srl_pkg::ANGLE_W-1:0] to,
                                               logic [31:0] elapsed, logic [31:0] len);
      logic [63:0] q;
      if (len == 0) begin
        return to;
      end
      if (to >= from) begin
        q = (64'(to) - 64'(from)) * 64'(elapsed) / 64'(len);
        return from + q[srl_pkg::ANGLE_W-1:0];
      end
      q = (64'(from) - 64'(to)) * 64'(elapsed) / 64'(len);
      return from - q[srl_pkg::ANGLE_W-1:0];
    endfunction

    function void record(bit done);
      angle_result_t res;
      foreach (last_ang[i]) res.ang[i] = last_ang[i];
      res.done = done;
      expected_angles.push_back(res);
    endfunction

    // returns 0 for a tick that finds no ramp running
    function bit note_request(ramp_request_t r);
      logic [31:0] per;
      logic [31:0] n;
      logic [31:0] elapsed;
      per = (period == 0) ? 32'd1 : 32'(period);
      if (r.cmd == srl_pkg::CMD_MOVE) begin
        if (32'(r.dur) <= per) begin
          foreach (last_ang[i]) last_ang[i] = r.tgt[i];
          busy     = 1'b0;
          tick_num = '0;
          record(1'b1);
        end else begin
          foreach (last_ang[i]) begin
            start_ang[i] = last_ang[i];
            goal_ang[i]  = r.tgt[i];
          end
          move_len = r.dur;
          tick_num = '0;
          busy     = 1'b1;
        end
        return 1'b1;
      end
      if (!busy) begin
        return 1'b0;
      end
      n       = 32'(tick_num) + 32'd1;
      elapsed = n * per;
      if (n > 32'hFFFF || elapsed >= 32'(move_len)) begin
        foreach (last_ang[i]) last_ang[i] = goal_ang[i];
        busy = 1'b0;
        record(1'b1);
      end else begin
        foreach (last_ang[i]) last_ang[i] = lerp(start_ang[i], goal_ang[i], elapsed, 32'(move_len));
        record(1'b0);
      end
      tick_num = n[srl_pkg::DUR_W-1:0];
      return 1'b1;
    endfunction

    function void check_angles(angle_result_t got);
      angle_result_t want;
      bit bad;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: angles %0d %0d %0d %0d done %0b", $realtime,
                   got.ang[0], got.ang[1], got.ang[2], got.ang[3], got.done);
        return;
      end
      want = expected_angles.pop_front();
      bad  = (got.done !== want.done);
      for (int i = 0; i < srl_pkg::IO_CHANNELS; i++) begin
        if (got.ang[i] !== want.ang[i]) bad = 1'b1;
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected %0d %0d %0d %0d done %0b, got %0d %0d %0d %0d done %0b",
                   $realtime, want.ang[0], want.ang[1], want.ang[2], want.ang[3], want.done,
                   got.ang[0], got.ang[1], got.ang[2], got.ang[3], got.done);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [srl_pkg::PERIOD_W-1:0]   tick_period_ms;
  logic                           cmd_valid;
  logic                           cmd_ready;
  logic                           command;
  logic [srl_pkg::DUR_W-1:0]      duration_ms;
  logic [srl_pkg::ANGLE_W-1:0]    target_a;
  logic [srl_pkg::ANGLE_W-1:0]    target_b;
  logic [srl_pkg::ANGLE_W-1:0]    target_c;
  logic [srl_pkg::ANGLE_W-1:0]    target_d;
  logic                           res_valid;
  logic                           res_ready;
  logic [srl_pkg::ANGLE_W-1:0]    angle_a;
  logic [srl_pkg::ANGLE_W-1:0]    angle_b;
  logic [srl_pkg::ANGLE_W-1:0]    angle_c;
  logic [srl_pkg::ANGLE_W-1:0]    angle_d;
  logic                           move_done;

  ramp_scoreboard ramp = new();
  bit             steady = 1'b0;
  bit             hold_req = 1'b0;
  int             useful_items = 0;
  logic [srl_pkg::PERIOD_W-1:0] cur_period = srl_pkg::RESET_TICK_PERIOD;

  servo_linear_ramp_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .tick_period_ms (tick_period_ms),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .command        (command),
    .duration_ms    (duration_ms),
    .target_a       (target_a),
    .target_b       (target_b),
    .target_c       (target_c),
    .target_d       (target_d),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .angle_a        (angle_a),
    .angle_b        (angle_b),
    .angle_c        (angle_c),
    .angle_d        (angle_d),
    .move_done      (move_done)
  );

  always #5 clk = ~clk;

  function automatic ramp_request_t move_request(logic [srl_pkg::DUR_W-1:0] dur);
    ramp_request_t r;
    bit wide;
    wide  = ($urandom_range(9) < 3);
    r.cmd = srl_pkg::CMD_MOVE;
    r.dur = dur;
    for (int i = 0; i < srl_pkg::IO_CHANNELS; i++)
      r.tgt[i] = wide ? 8'($urandom_range(255)) : 8'($urandom_range(180));
    return r;
  endfunction

  function automatic ramp_request_t fixed_move(logic [srl_pkg::DUR_W-1:0] dur,
                                               logic [srl_pkg::ANGLE_W-1:0] a,
                                               logic [srl_pkg::ANGLE_W-1:0] b,
                                               logic [srl_pkg::ANGLE_W-1:0] c,
                                               logic [srl_pkg::ANGLE_W-1:0] d);
    ramp_request_t r;
    r.cmd = srl_pkg::CMD_MOVE;
    r.dur = dur;
    r.tgt = {d, c, b, a};
    return r;
  endfunction

  // tick payload fields are don't-care, filled with noise
  function automatic ramp_request_t tick_request();
    ramp_request_t r;
    r.cmd = srl_pkg::CMD_TICK;
    r.dur = 16'($urandom_range(65535));
    for (int i = 0; i < srl_pkg::IO_CHANNELS; i++) r.tgt[i] = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic send_request(ramp_request_t r);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 24)
      gap = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 50);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid   <= 1'b1;
    command     <= r.cmd;
    duration_ms <= r.dur;
    target_a    <= r.tgt[0];
    target_b    <= r.tgt[1];
    target_c    <= r.tgt[2];
    target_d    <= r.tgt[3];
    do @(posedge clk); while (!cmd_ready);
    if (ramp.note_request(r)) useful_items++;
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_request(tick_request());
  endtask

  task automatic wait_drained(int settle);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (ramp.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_period(logic [srl_pkg::PERIOD_W-1:0] p);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    tick_period_ms <= p;
    do @(posedge clk); while (!cfg_ready);
    ramp.set_period(p);
    cur_period = p;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one move and the ticks that follow it, or a stray tick or move
  task automatic random_burst();
    int unsigned per;
    int unsigned dur;
    int unsigned need;
    int unsigned ticks;
    int unsigned pick;
    per  = (cur_period == 0) ? 1 : cur_period;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_request(($urandom_range(1) == 0) ? tick_request()
                                            : move_request(16'($urandom_range(65535))));
      return;
    end
    if (pick < 22) dur = $urandom_range(per);
    else if (pick < 32) dur = $urandom_range(65535);
    else dur = per * $urandom_range(1, 12) + $urandom_range(1, per);
    send_request(move_request(16'(dur)));
    if (dur <= per) return;
    need = (dur + per - 1) / per;
    if (need <= 40 && $urandom_range(9) < 7) ticks = need + $urandom_range(1);
    else ticks = $urandom_range((need > 30) ? 30 : need - 1);
    send_ticks(ticks);
  endtask

  task automatic random_phase(logic [srl_pkg::PERIOD_W-1:0] p, int count);
    int goal;
    wait_drained(60);
    write_period(p);
    goal = useful_items + count;
    while (useful_items < goal) random_burst();
  endtask

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      ramp.check_angles({angle_d, angle_c, angle_b, angle_a, move_done});
  end

  initial begin
    #8ms;
    $display("servo_linear_ramp_unit_tb: FAIL");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    tick_period_ms = srl_pkg::RESET_TICK_PERIOD;
    cmd_valid      = 1'b0;
    command        = srl_pkg::CMD_MOVE;
    duration_ms    = '0;
    target_a       = '0;
    target_b       = '0;
    target_c       = '0;
    target_d       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset period of 10
    send_ticks(1);
    send_request(fixed_move(16'd0, 8'd0, 8'd255, 8'd180, 8'd90));
    send_request(fixed_move(16'd10, 8'd255, 8'd0, 8'd90, 8'd180));
    send_request(fixed_move(16'd11, 8'd0, 8'd180, 8'd255, 8'd45));
    send_ticks(3);
    send_request(fixed_move(16'hFFFF, 8'd255, 8'd0, 8'd255, 8'd0));
    send_ticks(3);
    // restart from the last output angles
    send_request(fixed_move(16'd30, 8'd90, 8'd90, 8'd0, 8'd180));
    send_ticks(3);
    // short move cancels a running ramp
    send_request(fixed_move(16'd40000, 8'd170, 8'd1, 8'd128, 8'd64));
    send_ticks(1);
    send_request(fixed_move(16'd5, 8'd85, 8'd170, 8'd51, 8'd204));
    send_ticks(1);

    // period zero acts as one
    random_phase(7'd0, 300);

    wait_drained(60);
    write_period(7'd127);
    hold_req = 1'b1;
    send_request(move_request(16'hFFFF));
    send_ticks(20);
    begin : wide_period
      int goal;
      goal = useful_items + 280;
      while (useful_items < goal) random_burst();
    end

    steady = 1'b1;
    random_phase(7'd1, 300);
    steady = 1'b0;

    random_phase(7'd100, 300);
    random_phase(7'($urandom_range(2, 99)), 300);
    random_phase(srl_pkg::RESET_TICK_PERIOD, 300);

    wait_drained(100);
    if (ramp.errors() == 0)
      $display("servo_linear_ramp_unit_tb: PASS");
    else
      $display("servo_linear_ramp_unit_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/srl_pkg.sv
design/srl_ctrl.sv
design/srl_dp.sv
design/servo_linear_ramp_unit.sv
bench/servo_linear_ramp_unit_tb.sv
